FILE: sv/aep_pkg.sv
// ----------------------------------------------------------------------------
// aep_pkg
// Types and constants shared by the adaptive knob smoothing filter.
// ----------------------------------------------------------------------------
package aep_pkg;

  localparam int NUM_SLOTS      = 6;
  localparam int KNOBS_PER_BANK = NUM_SLOTS / 2;
  localparam int SLOT_W         = $clog2(NUM_SLOTS);
  localparam int KIDX_W         = (KNOBS_PER_BANK > 1) ? $clog2(KNOBS_PER_BANK) : 1;

  localparam int KNOB_W   = 2;
  localparam int SAMPLE_W = 15;
  localparam int COARSE_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam int SPEED_SHIFT = 4;
  localparam int WSUM_W      = SAMPLE_W + SPEED_SHIFT + 1;

  localparam logic [SAMPLE_W-1:0] ALPHA_RESET  = 15'd2213;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 15'd256;
  localparam logic [SAMPLE_W-1:0] TOP_LEVEL    = 15'h7FE0;
  localparam logic [SAMPLE_W-1:0] TOP_BIAS     = 15'h001F;
  localparam logic [SAMPLE_W-1:0] WEIGHT_MAX   = 15'h7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_BASE     = 2'd0,
    CFG_MOVE_THRESHOLD = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [KNOB_W-1:0]   knob;
    logic                bank;
    logic [SAMPLE_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                moved;
    logic [COARSE_W-1:0] coarse;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  wdata;
  } cfg_item_t;

endpackage

FILE: sv/aep_if.sv
// ----------------------------------------------------------------------------
// aep_if
// Valid/ready channels of the adaptive knob smoothing filter.
// ----------------------------------------------------------------------------
interface aep_in_if;
  import aep_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface aep_out_if;
  import aep_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface aep_cfg_if;
  import aep_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

FILE: sv/adaptive_ema_pot_filter.sv
// ----------------------------------------------------------------------------
// adaptive_ema_pot_filter
// Speed-adaptive exponential moving average over a bank of knob samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one request per knob sample (knob, bank, raw_sample).
//   out_o  returns one request per sample: filtered value, moved flag and
//          the coarse value (filtered >> 8).
//   cfg_i  writes alpha_base (index 0) or move_threshold (index 1); other
//          indexes are dropped. cfg_i is always ready; write only while idle.
// Timing:
//   a sample is taken into the input register; its result is then registered
//   in the output register and shown on out_o. One sample per cycle is
//   sustained while out_o is not held: the input register, one 16x17 multiply
//   and the read-modify-write of the slot registers all sit in one stage.
//   the state is read and written in that stage, so back-to-back samples
//   on the same knob see each other's updates with no extra wait.
// Reset:
//   all filtered slots and previous samples clear to zero, alpha_base and
//   move_threshold return to their defaults, both channels empty.
// Stall:
//   while out_o is held, a result waits in the output register and one more
//   sample is taken into the input register; in_i then drops ready.
// ----------------------------------------------------------------------------
module adaptive_ema_pot_filter import aep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  aep_cfg_if.sink      cfg_i,
  aep_in_if.sink       in_i,
  aep_out_if.source    out_o
);

  logic [SAMPLE_W-1:0] alpha_q, thresh_q;
  logic [SAMPLE_W-1:0] smooth_q [NUM_SLOTS];
  logic [SAMPLE_W-1:0] prev_q   [KNOBS_PER_BANK];

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic adv, in_rdy, fire, knob_ok;
  logic [KIDX_W-1:0]   kidx;
  logic [SLOT_W-1:0]   slot;
  logic [SAMPLE_W-1:0] raw, old, prev, speed, weight, nv_avg, nv, chg;
  logic [WSUM_W-1:0]   wsum;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W+1:0] wt_s;
  logic signed [31:0]         prod, acc;

  // handshake
  assign adv         = !out_valid_q || out_o.ready;
  assign in_rdy      = !s1_valid_q || adv;
  assign in_i.ready  = in_rdy;
  assign fire        = s1_valid_q && adv;
  assign s1_valid_d  = in_rdy ? in_i.valid : s1_valid_q;
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.req   = out_q;
  assign cfg_i.ready = 1'b1;

  // slot select
  assign knob_ok = (32'(s1_q.knob) < KNOBS_PER_BANK);
  assign kidx    = KIDX_W'(s1_q.knob);
  assign slot    = s1_q.bank ? SLOT_W'(KNOBS_PER_BANK) + SLOT_W'(s1_q.knob)
                             : SLOT_W'(s1_q.knob);
  assign raw     = s1_q.raw_sample;
  assign old     = smooth_q[slot];
  assign prev    = prev_q[kidx];

  // speed-boosted weight
  assign speed  = (raw >= prev) ? raw - prev : prev - raw;
  assign wsum   = WSUM_W'(alpha_q) + {1'b0, speed, {SPEED_SHIFT{1'b0}}};
  assign weight = (|wsum[WSUM_W-1:SAMPLE_W]) ? WEIGHT_MAX : wsum[SAMPLE_W-1:0];

  // old + floor((raw - old) * weight / 2^15)
  assign diff   = $signed({1'b0, raw}) - $signed({1'b0, old});
  assign wt_s   = $signed({2'b00, weight});
  assign prod   = 32'(diff) * 32'(wt_s);
  assign acc    = prod + $signed({2'b00, old, {SAMPLE_W{1'b0}}});
  assign nv_avg = acc[2*SAMPLE_W-1:SAMPLE_W];
  assign nv     = (raw >= TOP_LEVEL) ? (nv_avg | TOP_BIAS) : nv_avg;
  assign chg    = (nv >= old) ? nv - old : old - nv;

  always_comb begin
    out_d = '0;
    if (knob_ok) begin
      out_d.filtered = nv;
      out_d.moved    = (chg >= thresh_q);
      out_d.coarse   = nv[SAMPLE_W-1:SAMPLE_W-COARSE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      s1_q <= in_i.req;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      thresh_q <= THRESH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.req.index))
        CFG_ALPHA_BASE:     alpha_q  <= cfg_i.req.wdata;
        CFG_MOVE_THRESHOLD: thresh_q <= cfg_i.req.wdata;
        default: ;
      endcase
    end
  end

  // slot and previous-sample state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        smooth_q[i] <= '0;
      end
      for (int k = 0; k < KNOBS_PER_BANK; k++) begin
        prev_q[k] <= '0;
      end
    end else if (fire && knob_ok) begin
      smooth_q[slot] <= nv;
      prev_q[kidx]   <= raw;
    end
  end

endmodule

FILE: sv/aep_checker.sv
// ----------------------------------------------------------------------------
// aep_checker
// Port-level checks for the adaptive knob smoothing filter.
// ----------------------------------------------------------------------------
module aep_checker import aep_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  aep_cfg_if.sink   cfg_i,
  aep_in_if.sink    in_i,
  aep_out_if.source out_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.req))
    else $error("stalled result changed");

  // coarse follows filtered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.req.coarse == out_o.req.filtered[SAMPLE_W-1:SAMPLE_W-COARSE_W])
    else $error("coarse does not match filtered");

  // input only backs up behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output back-pressure");

  // config port never blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |-> cfg_i.ready)
    else $error("config write refused");

endmodule

bind adaptive_ema_pot_filter aep_checker u_aep_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cfg_i  (cfg_i),
  .in_i   (in_i),
  .out_o  (out_o)
);

FILE: tb/tb_adaptive_ema_pot_filter.sv
// ----------------------------------------------------------------------------
// tb_adaptive_ema_pot_filter
// Self-checking bench for the speed-adaptive knob smoothing filter. A table of
// directed samples and register writes comes first. Random phases follow,
// each with its own weight and threshold setting, and mostly drifting knob
// sequences. Every result is checked field by field against an in-bench
// model of the smoothing slots, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_adaptive_ema_pot_filter;
  import aep_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 142;
  localparam int DRAIN_CYCLES    = 4;
  localparam int NUM_DIR         = 25;

  localparam logic [KNOB_W-1:0]    KNOB_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_item_t cfg;
    in_item_t  smp;
    logic      known;
    out_item_t want;
  } dir_row_t;

  // known rows carry a result that follows directly from reset, saturation or an unused knob
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_SAMPLE, '0, '{KNOB_UNUSED, 1'b0, 15'h7FFF}, 1'b1, '{15'h0000, 1'b0, 7'h00}},
    '{ROW_SAMPLE, '0, '{KNOB_UNUSED, 1'b1, 15'h1234}, 1'b1, '{15'h0000, 1'b0, 7'h00}},
    '{ROW_SAMPLE, '0, '{2'd0, 1'b0, 15'h0000}, 1'b1, '{15'h0000, 1'b0, 7'h00}},
    '{ROW_CFG, '{CFG_ALPHA_BASE, 15'h7FFF}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd1, 1'b0, 15'h7FFF}, 1'b1, '{15'h7FFF, 1'b1, 7'h7F}},
    '{ROW_SAMPLE, '0, '{2'd1, 1'b1, 15'h7FE0}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd1, 1'b0, 15'h0000}, 1'b1, '{15'h0000, 1'b1, 7'h00}},
    '{ROW_CFG, '{CFG_ALPHA_BASE, 15'h0000}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd2, 1'b0, 15'h4000}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd2, 1'b0, 15'h4000}, 1'b0, '0},
    '{ROW_CFG, '{CFG_MOVE_THRESHOLD, 15'h0000}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd2, 1'b0, 15'h4000}, 1'b0, '0},
    '{ROW_CFG, '{CFG_MOVE_THRESHOLD, 15'h7FFF}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd0, 1'b1, 15'h7FFF}, 1'b0, '0},
    '{ROW_CFG, '{CFG_SPARE_2, 15'h0001}, '0, 1'b0, '0},
    '{ROW_CFG, '{CFG_SPARE_3, 15'h7FFF}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd0, 1'b1, 15'h7FFF}, 1'b0, '0},
    '{ROW_CFG, '{CFG_ALPHA_BASE, ALPHA_RESET}, '0, 1'b0, '0},
    '{ROW_CFG, '{CFG_MOVE_THRESHOLD, THRESH_RESET}, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd0, 1'b0, 15'h5555}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd0, 1'b0, 15'h2AAA}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd2, 1'b1, 15'h7FDF}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd2, 1'b1, 15'h7FE0}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd1, 1'b0, 15'h7FFF}, 1'b0, '0},
    '{ROW_SAMPLE, '0, '{2'd1, 1'b1, 15'h0000}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  aep_cfg_if cfg_if ();
  aep_in_if  in_if ();
  aep_out_if out_if ();

  adaptive_ema_pot_filter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // model of the smoothing slots
  logic [SAMPLE_W-1:0] smooth_mem [NUM_SLOTS]      = '{default: '0};
  logic [SAMPLE_W-1:0] last_raw   [KNOBS_PER_BANK] = '{default: '0};
  logic [SAMPLE_W-1:0] alpha_cfg  = ALPHA_RESET;
  logic [SAMPLE_W-1:0] thresh_cfg = THRESH_RESET;

  out_item_t pending_smooth [$];

  logic      row_known = 1'b0;
  out_item_t row_want  = '0;

  int cycles     = 0;
  int errors     = 0;
  int n_samples  = 0;
  int n_unused   = 0;
  int n_writes   = 0;
  int n_results  = 0;
  int burst_left = 0;
  int gap_left   = 0;
  bit idle_tx    = 1'b1;
  bit rx_stall   = 1'b1;
  int knob_pos [4] = '{default: 0};

  function automatic out_item_t next_smoothed(input in_item_t s);
    out_item_t   r;
    int unsigned slot, raw, prev, old, spd, w, nv, dif;
    r = '0;
    if (32'(s.knob) >= KNOBS_PER_BANK) return r;
    slot = int'(s.bank) * KNOBS_PER_BANK + int'(s.knob);
    raw  = 32'(s.raw_sample);
    prev = 32'(last_raw[s.knob]);
    spd  = (raw >= prev) ? raw - prev : prev - raw;
    last_raw[s.knob] = s.raw_sample;
    w = 32'(alpha_cfg) + (spd << SPEED_SHIFT);
    if (w > 32'(WEIGHT_MAX)) w = 32'(WEIGHT_MAX);
    old = 32'(smooth_mem[slot]);
    // floor toward minus infinity on the falling side
    if (raw >= old) nv = old + (((raw - old) * w) >> SAMPLE_W);
    else nv = old - ((((old - raw) * w) + 32'(WEIGHT_MAX)) >> SAMPLE_W);
    if (raw >= 32'(TOP_LEVEL)) nv = nv | 32'(TOP_BIAS);
    nv = nv & 32'(WEIGHT_MAX);
    smooth_mem[slot] = nv[SAMPLE_W-1:0];
    dif = (nv >= old) ? nv - old : old - nv;
    r.filtered = nv[SAMPLE_W-1:0];
    r.moved    = (dif >= 32'(thresh_cfg));
    r.coarse   = nv[SAMPLE_W-1:8];
    return r;
  endfunction

  function automatic in_item_t rand_sample();
    in_item_t s;
    int       v;
    s.knob = ($urandom_range(0, 19) == 0) ? KNOB_UNUSED : KNOB_W'($urandom_range(0, 2));
    s.bank = 1'($urandom_range(0, 1));
    v = knob_pos[s.knob];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = v + int'($urandom_range(0, 128)) - 64;
      5:             v = int'($urandom_range(0, 32767));
      6:             v = int'($urandom_range(32704, 32767));
      7:             v = $urandom_range(0, 1) ? 32767 : 0;
      default:       ;
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    knob_pos[s.knob] = v;
    s.raw_sample = v[SAMPLE_W-1:0];
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_smooth.size());
      $display("Verification failed");
      $finish;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        n_writes++;
        case (cfg_if.req.index)
          CFG_ALPHA_BASE:     alpha_cfg  = cfg_if.req.wdata;
          CFG_MOVE_THRESHOLD: thresh_cfg = cfg_if.req.wdata;
          default:            ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        n_samples++;
        if (32'(in_if.req.knob) >= KNOBS_PER_BANK) n_unused++;
        want = next_smoothed(in_if.req);
        pending_smooth.push_back(row_known ? row_want : want);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.req;
        n_results++;
        if (pending_smooth.size() == 0) begin
          if (errors < 10) $display("unexpected result %p at cycle %0d", got, cycles);
          errors++;
        end else begin
          want = pending_smooth.pop_front();
          if (got.filtered !== want.filtered || got.moved !== want.moved ||
              got.coarse !== want.coarse) begin
            if (errors < 10)
              $display("mismatch at cycle %0d: expected %p, got %p", cycles, want, got);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int run;
    run = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rx_stall) begin
        out_if.ready <= 1'b1;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (out_if.ready) begin
        out_if.ready <= 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b1;
        run = $urandom_range(0, 10);
      end
    end
  end

  task automatic push_sample(input in_item_t s, input logic known, input out_item_t want);
    while (gap_left > 0) begin
      in_if.valid <= 1'b0;
      gap_left--;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req   <= s;
    row_known   <= known;
    row_want    <= want;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!idle_tx) gap_left = 0;
      else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(8, 30);
      else gap_left = $urandom_range(1, 4);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    in_if.valid <= 1'b0;
    while (pending_smooth.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.req   <= '{index: idx, wdata: val};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [SAMPLE_W-1:0] a_val;
    logic [SAMPLE_W-1:0] t_val;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.req    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.req   = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG)
        write_reg(DIR_ROWS[i].cfg.index, DIR_ROWS[i].cfg.wdata);
      else
        push_sample(DIR_ROWS[i].smp, DIR_ROWS[i].known, DIR_ROWS[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin a_val = ALPHA_RESET; t_val = THRESH_RESET; end
        1: begin a_val = '0;          t_val = '0;           end
        2: begin a_val = WEIGHT_MAX;  t_val = WEIGHT_MAX;   end
        3: begin
          a_val = SAMPLE_W'($urandom_range(0, 255));
          t_val = SAMPLE_W'($urandom_range(0, 63));
        end
        default: begin
          a_val = SAMPLE_W'($urandom);
          t_val = $urandom_range(0, 1) ? SAMPLE_W'($urandom) : SAMPLE_W'($urandom_range(0, 1023));
        end
      endcase
      idle_tx  = (p % 3 != 1);
      rx_stall = (p % 4 != 2);
      write_reg(CFG_ALPHA_BASE, a_val);
      write_reg(CFG_MOVE_THRESHOLD, t_val);
      if (p % 2 == 1)
        write_reg((p % 4 == 1) ? CFG_SPARE_2 : CFG_SPARE_3, SAMPLE_W'($urandom));
      repeat (ITEMS_PER_PHASE) push_sample(rand_sample(), 1'b0, '0);
    end

    in_if.valid <= 1'b0;
    while (pending_smooth.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("%0d knob samples (%0d on the unused knob) over %0d weight/threshold phases",
             n_samples, n_unused, NUM_PHASES);
    $display("%0d register writes, %0d results compared, %0d mismatches",
             n_writes, n_results, errors);
    if (errors == 0 && pending_smooth.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
